// ===== rtl/msa_pkg.sv =====
// package of the minimum spanning arborescence unit: types, codes and sizes
package msa_pkg;

	localparam int DEF_MAX_VERTICES = 256;
	localparam int DEF_MAX_EDGES    = 4096;
	localparam int COST_W           = 48;

	localparam logic CFG_ROOT   = 1'b0;
	localparam logic CFG_VCOUNT = 1'b1;

	typedef enum logic [4:0] {
		ST_LOAD,
		ST_C_RD,
		ST_C_CHK,
		ST_R_INIT,
		ST_E_RD,
		ST_E_VRD,
		ST_E_CHK,
		ST_V_RD,
		ST_V_CHK,
		ST_W_START,
		ST_W_RD,
		ST_W_CHK,
		ST_K_RD,
		ST_K_CHK,
		ST_F_RD,
		ST_F_CHK,
		ST_X_RD,
		ST_X_SRD,
		ST_X_DRD,
		ST_X_UPD,
		ST_ROOT_RD,
		ST_ROOT_UPD,
		ST_DONE
	} msa_state_t;

endpackage

// ===== rtl/msa_ram.sv =====
// generic single write port, single read port ram with registered read
module msa_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rdata <= mem[raddr];
	end

endmodule

// ===== rtl/min_spanning_arborescence_unit.sv =====
// minimum spanning arborescence unit: edge loading and chu-liu/edmonds solver
//
// Edges arrive on the edge channel (edge_valid/edge_stall), one beat per
// cycle while edge_stall is low, and are written to the edge memory.
// Out-of-range edges and edges beyond the memory size are dropped and
// flagged. The beat with last_edge set starts the solver; edge_stall stays
// high until it is done. The solver first compacts the edge memory, then
// runs at most V rounds of cheapest pick, check, cycle walk, relabel and
// reweight; the vertex memory has a single read port. The result beat
// (total_weight, no_arborescence, edges_dropped) sits in an output
// register on result_valid/result_stall; a new graph may load while it
// waits, and a later result waits in the solver until it is taken. The
// user must write configuration (cfg_we, cfg_index, cfg_data) only while
// idle; the block itself does not enforce it. Reset clears the state, the
// root, edge count, sum and flags and sets the vertex count to 1; the
// memories are not cleared, since every entry is written before it is read.
module min_spanning_arborescence_unit
	import msa_pkg::*;
#(
	parameter int MAX_VERTICES = DEF_MAX_VERTICES,
	parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [8:0]         cfg_data,
	input  logic               edge_valid,
	output logic               edge_stall,
	input  logic [7:0]         edge_from,
	input  logic [7:0]         edge_to,
	input  logic signed [31:0] edge_weight,
	input  logic               last_edge,
	output logic               result_valid,
	input  logic               result_stall,
	output logic signed [47:0] total_weight,
	output logic               no_arborescence,
	output logic               edges_dropped
);

	localparam int VW  = $clog2(MAX_VERTICES);
	localparam int NW  = $clog2(MAX_VERTICES + 1);
	localparam int AW  = $clog2(MAX_EDGES);
	localparam int EW  = $clog2(MAX_EDGES + 1);
	localparam int CW  = (NW > 9) ? NW : 9;
	localparam int EDW = 2 * VW + COST_W;
	localparam int MK_LO  = 0;
	localparam int LAB_B  = NW;
	localparam int LBL_LO = NW + 1;
	localparam int PRD_LO = LBL_LO + VW;
	localparam int CH_LO  = PRD_LO + VW;
	localparam int HAS_B  = CH_LO + COST_W;
	localparam int VDW    = HAS_B + 1;

	msa_state_t st_q, st_d;

	logic [7:0]  root_q;
	logic [8:0]  vcnt_q;
	logic [EW-1:0] total_q, e_q, m_q;
	logic [NW-1:0] i_q, n_q, cnt_q;
	logic [VW-1:0] r_q, v_q, u_q, es_q, ed_q, la_q;
	logic signed [COST_W-1:0] ec_q, sum_q;
	logic drop_q, fail_q;
	logic res_valid_q, res_noarb_q, res_drop_q;
	logic signed [COST_W-1:0] res_total_q;

	logic           ewe, vwe;
	logic [AW-1:0]  ewaddr, eraddr;
	logic [EDW-1:0] ewdata, erdata;
	logic [VW-1:0]  vwaddr, vraddr;
	logic [VDW-1:0] vwdata, vrdata;

	logic [CW-1:0] vext;
	logic [NW-1:0] n_eff;
	logic in_acc, keep, c_end, e_end, i_end, bad, out_free;

	logic [VW-1:0]            er_src, er_dst;
	logic signed [COST_W-1:0] er_cost;
	logic                     vr_has, vr_lab;
	logic signed [COST_W-1:0] vr_cheap;
	logic [VW-1:0]            vr_pred, vr_label;
	logic [NW-1:0]            vr_mark;

	assign er_src   = erdata[EDW-1 -: VW];
	assign er_dst   = erdata[COST_W +: VW];
	assign er_cost  = erdata[COST_W-1:0];
	assign vr_has   = vrdata[HAS_B];
	assign vr_cheap = vrdata[CH_LO +: COST_W];
	assign vr_pred  = vrdata[PRD_LO +: VW];
	assign vr_label = vrdata[LBL_LO +: VW];
	assign vr_lab   = vrdata[LAB_B];
	assign vr_mark  = vrdata[MK_LO +: NW];

	assign vext  = CW'(vcnt_q);
	assign n_eff = (vcnt_q == 9'd0) ? NW'(1) :
		(vext > CW'(MAX_VERTICES)) ? NW'(MAX_VERTICES) : NW'(vext);

	assign in_acc   = edge_valid && !edge_stall;
	assign keep     = (CW'(edge_from) < CW'(n_eff)) && (CW'(edge_to) < CW'(n_eff))
		&& (total_q < EW'(MAX_EDGES));
	assign c_end    = e_q >= total_q;
	assign e_end    = e_q >= m_q;
	assign i_end    = i_q >= n_q;
	assign bad      = (NW'(er_src) >= n_q) || (NW'(er_dst) >= n_q);
	assign out_free = !res_valid_q || !result_stall;

	assign edge_stall      = st_q != ST_LOAD;
	assign result_valid    = res_valid_q;
	assign total_weight    = res_total_q;
	assign no_arborescence = res_noarb_q;
	assign edges_dropped   = res_drop_q;

	msa_ram #(.WIDTH(EDW), .DEPTH(MAX_EDGES)) u_edge_ram (
		.clk(clk), .we(ewe), .waddr(ewaddr), .wdata(ewdata),
		.raddr(eraddr), .rdata(erdata)
	);

	msa_ram #(.WIDTH(VDW), .DEPTH(MAX_VERTICES)) u_vtx_ram (
		.clk(clk), .we(vwe), .waddr(vwaddr), .wdata(vwdata),
		.raddr(vraddr), .rdata(vrdata)
	);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_LOAD:     if (in_acc && last_edge) st_d = ST_C_RD;
			ST_C_RD:     if (!c_end) st_d = ST_C_CHK;
				else if (CW'(root_q) >= CW'(n_q)) st_d = ST_DONE;
				else st_d = ST_R_INIT;
			ST_C_CHK:    st_d = ST_C_RD;
			ST_R_INIT:   if (i_end) st_d = ST_E_RD;
			ST_E_RD:     st_d = e_end ? ST_V_RD : ST_E_VRD;
			ST_E_VRD:    st_d = ST_E_CHK;
			ST_E_CHK:    st_d = ST_E_RD;
			ST_V_RD:     st_d = i_end ? ST_W_START : ST_V_CHK;
			ST_V_CHK:    st_d = (NW'(r_q) != i_q && !vr_has) ? ST_DONE : ST_V_RD;
			ST_W_START:  if (i_end) st_d = (cnt_q == '0) ? ST_DONE : ST_F_RD;
				else if (i_q != NW'(r_q)) st_d = ST_W_RD;
			ST_W_RD:     st_d = (v_q == r_q) ? ST_W_START : ST_W_CHK;
			ST_W_CHK:    if (vr_mark == '0 && !vr_lab) st_d = ST_W_RD;
				else if (!vr_lab && vr_mark == i_q + NW'(1)) st_d = ST_K_RD;
				else st_d = ST_W_START;
			ST_K_RD:     st_d = ST_K_CHK;
			ST_K_CHK:    st_d = (vr_pred == v_q) ? ST_W_START : ST_K_RD;
			ST_F_RD:     st_d = i_end ? ST_X_RD : ST_F_CHK;
			ST_F_CHK:    st_d = ST_F_RD;
			ST_X_RD:     st_d = e_end ? ST_ROOT_RD : ST_X_SRD;
			ST_X_SRD:    st_d = ST_X_DRD;
			ST_X_DRD:    st_d = ST_X_UPD;
			ST_X_UPD:    st_d = ST_X_RD;
			ST_ROOT_RD:  st_d = ST_ROOT_UPD;
			ST_ROOT_UPD: st_d = ST_R_INIT;
			ST_DONE:     if (out_free) st_d = ST_LOAD;
			default:     st_d = ST_LOAD;
		endcase
	end

	// memory controls
	always_comb begin
		ewe    = 1'b0;
		ewaddr = total_q[AW-1:0];
		ewdata = {VW'(edge_from), VW'(edge_to), COST_W'(edge_weight)};
		eraddr = e_q[AW-1:0];
		vwe    = 1'b0;
		vwaddr = vraddr;
		vwdata = vrdata;
		vraddr = i_q[VW-1:0];
		unique case (st_q)
			ST_LOAD: ewe = in_acc && keep;
			ST_C_CHK: begin
				ewe    = !bad;
				ewaddr = m_q[AW-1:0];
				ewdata = erdata;
			end
			ST_R_INIT: begin
				vwe    = !i_end;
				vwaddr = i_q[VW-1:0];
				vwdata = '0;
			end
			ST_E_VRD: vraddr = er_dst;
			ST_E_CHK: begin
				vraddr = ed_q;
				vwaddr = ed_q;
				vwe = (es_q != ed_q) && (ed_q != r_q) && (!vr_has || ec_q < vr_cheap);
				vwdata[HAS_B] = 1'b1;
				vwdata[CH_LO +: COST_W] = ec_q;
				vwdata[PRD_LO +: VW] = es_q;
			end
			ST_W_RD, ST_W_CHK: begin
				vraddr = v_q;
				vwaddr = v_q;
				vwe = (st_q == ST_W_CHK) && vr_mark == '0 && !vr_lab;
				vwdata[MK_LO +: NW] = i_q + NW'(1);
			end
			ST_K_RD, ST_K_CHK: begin
				vraddr = u_q;
				vwaddr = u_q;
				vwe = st_q == ST_K_CHK;
				vwdata[LBL_LO +: VW] = cnt_q[VW-1:0];
				vwdata[LAB_B] = 1'b1;
			end
			ST_F_CHK: begin
				vwaddr = i_q[VW-1:0];
				vwe = !vr_lab;
				vwdata[LBL_LO +: VW] = cnt_q[VW-1:0];
			end
			ST_X_SRD: vraddr = er_src;
			ST_X_DRD: vraddr = ed_q;
			ST_X_UPD: begin
				ewe    = 1'b1;
				ewaddr = e_q[AW-1:0];
				ewdata = {la_q, vr_label,
					(la_q != vr_label && ed_q != r_q) ? ec_q - vr_cheap : ec_q};
				vraddr = ed_q;
			end
			ST_ROOT_RD, ST_ROOT_UPD: vraddr = r_q;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= ST_LOAD;
			root_q      <= '0;
			vcnt_q      <= 9'd1;
			total_q     <= '0;
			sum_q       <= '0;
			drop_q      <= 1'b0;
			fail_q      <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				unique case (cfg_index)
					CFG_ROOT:   root_q <= cfg_data[7:0];
					CFG_VCOUNT: vcnt_q <= cfg_data;
					default: ;
				endcase
			end
			if (st_q == ST_DONE && out_free)
				res_valid_q <= 1'b1;
			else if (!result_stall)
				res_valid_q <= 1'b0;
			unique case (st_q)
				ST_LOAD: if (in_acc) begin
					if (keep) total_q <= total_q + EW'(1);
					else drop_q <= 1'b1;
					e_q    <= '0;
					m_q    <= '0;
					n_q    <= n_eff;
					sum_q  <= '0;
					fail_q <= 1'b0;
				end
				ST_C_RD: if (c_end) begin
					fail_q <= CW'(root_q) >= CW'(n_q);
					r_q    <= VW'(root_q);
					i_q    <= '0;
				end
				ST_C_CHK: begin
					if (bad) drop_q <= 1'b1;
					else m_q <= m_q + EW'(1);
					e_q <= e_q + EW'(1);
				end
				ST_R_INIT: begin
					if (i_end) e_q <= '0;
					else i_q <= i_q + NW'(1);
				end
				ST_E_RD: if (e_end) i_q <= '0;
				ST_E_VRD: begin
					es_q <= er_src;
					ed_q <= er_dst;
					ec_q <= er_cost;
				end
				ST_E_CHK: e_q <= e_q + EW'(1);
				ST_V_RD: if (i_end) begin
					i_q   <= '0;
					cnt_q <= '0;
				end
				ST_V_CHK: begin
					if (NW'(r_q) != i_q) begin
						if (!vr_has) fail_q <= 1'b1;
						else sum_q <= sum_q + vr_cheap;
					end
					i_q <= i_q + NW'(1);
				end
				ST_W_START: begin
					if (i_end) i_q <= '0;
					else if (i_q == NW'(r_q)) i_q <= i_q + NW'(1);
					else v_q <= i_q[VW-1:0];
				end
				ST_W_RD: if (v_q == r_q) i_q <= i_q + NW'(1);
				ST_W_CHK: begin
					if (vr_mark == '0 && !vr_lab) v_q <= vr_pred;
					else if (!vr_lab && vr_mark == i_q + NW'(1)) u_q <= v_q;
					else i_q <= i_q + NW'(1);
				end
				ST_K_CHK: begin
					u_q <= vr_pred;
					if (vr_pred == v_q) begin
						cnt_q <= cnt_q + NW'(1);
						i_q   <= i_q + NW'(1);
					end
				end
				ST_F_RD: if (i_end) e_q <= '0;
				ST_F_CHK: begin
					if (!vr_lab) cnt_q <= cnt_q + NW'(1);
					i_q <= i_q + NW'(1);
				end
				ST_X_SRD: begin
					ed_q <= er_dst;
					ec_q <= er_cost;
				end
				ST_X_DRD: la_q <= vr_label;
				ST_X_UPD: e_q <= e_q + EW'(1);
				ST_ROOT_UPD: begin
					r_q <= vr_label;
					n_q <= cnt_q;
					i_q <= '0;
				end
				ST_DONE: if (out_free) begin
					res_total_q <= fail_q ? '0 : sum_q;
					res_noarb_q <= fail_q;
					res_drop_q  <= drop_q;
					total_q     <= '0;
					sum_q       <= '0;
					drop_q      <= 1'b0;
					fail_q      <= 1'b0;
				end
				default: ;
			endcase
		end
	end

endmodule

// ===== rtl/msa_checker.sv =====
// port-level assertions for the minimum spanning arborescence unit
module msa_checker
	import msa_pkg::*;
(
	input logic               clk,
	input logic               arst_n,
	input logic               edge_valid,
	input logic               edge_stall,
	input logic               result_valid,
	input logic               result_stall,
	input logic signed [47:0] total_weight,
	input logic               no_arborescence,
	input logic               edges_dropped
);

	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && result_stall |=> result_valid)
		else $error("result beat dropped under stall");

	a_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && no_arborescence |-> total_weight == '0)
		else $error("nonzero weight without arborescence");

	a_solve: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(result_valid) |-> $past(edge_stall))
		else $error("result without a solve");

endmodule

bind min_spanning_arborescence_unit msa_checker u_msa_checker (.*);

// ===== sim/testbench.sv =====
// testbench of the arborescence unit: directed and random graphs checked against a solver
module testbench;
	import msa_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int NV = DEF_MAX_VERTICES;
	localparam int NE = DEF_MAX_EDGES;
	localparam longint CYCLE_LIMIT = 20_000_000;

	typedef struct {
		logic [47:0] weight;
		bit          none;
		bit          dropped;
	} arb_result_t;

	class arb_scoreboard;
		int          src[NE], dst[NE];
		longint      cost[NE];
		int          stored;
		bit          dropped;
		int          root;
		int          vcount;
		arb_result_t pending_q[$];
		bit          has_in[NV];
		longint      best[NV];
		int          pred[NV], grp[NV], mark[NV];
		bit          lab[NV];

		function new();
			stored = 0;
			dropped = 0;
			root = 0;
			vcount = 1;
		endfunction

		function void write_reg(logic idx, logic [8:0] data);
			if (idx == CFG_ROOT)
				root = data[7:0];
			else
				vcount = data;
		endfunction

		function int eff_count();
			if (vcount == 0) return 1;
			if (vcount > NV) return NV;
			return vcount;
		endfunction

		function bit run_solver(output longint sum);
			int n, r, m, cnt, v, u, a, b;
			n = eff_count();
			r = root;
			m = 0;
			sum = 0;
			for (int e = 0; e < stored; e++) begin
				if (src[e] >= n || dst[e] >= n) begin
					dropped = 1;
					continue;
				end
				src[m] = src[e];
				dst[m] = dst[e];
				cost[m] = cost[e];
				m++;
			end
			if (r >= n) return 0;
			forever begin
				cnt = 0;
				for (int i = 0; i < n; i++) has_in[i] = 0;
				for (int e = 0; e < m; e++) begin
					a = src[e];
					b = dst[e];
					if (a != b && b != r && (!has_in[b] || cost[e] < best[b])) begin
						has_in[b] = 1;
						best[b] = cost[e];
						pred[b] = a;
					end
				end
				for (int i = 0; i < n; i++)
					if (i != r && !has_in[i]) return 0;
				for (int i = 0; i < n; i++)
					if (i != r) sum += best[i];
				for (int i = 0; i < n; i++) begin
					lab[i] = 0;
					mark[i] = 0;
				end
				for (int i = 0; i < n; i++) begin
					if (i == r) continue;
					v = i;
					while (mark[v] == 0 && !lab[v] && v != r) begin
						mark[v] = i + 1;
						v = pred[v];
					end
					if (v != r && !lab[v] && mark[v] == i + 1) begin
						u = v;
						do begin
							grp[u] = cnt;
							lab[u] = 1;
							u = pred[u];
						end while (u != v);
						cnt++;
					end
				end
				if (cnt == 0) break;
				for (int i = 0; i < n; i++)
					if (!lab[i]) grp[i] = cnt++;
				for (int e = 0; e < m; e++) begin
					a = grp[src[e]];
					b = grp[dst[e]];
					if (a != b && dst[e] != r) cost[e] -= best[dst[e]];
					src[e] = a;
					dst[e] = b;
				end
				r = grp[r];
				n = cnt;
			end
			return 1;
		endfunction

		function void note_edge(logic [7:0] from, logic [7:0] to, logic signed [31:0] w,
				logic last);
			int n;
			longint sum;
			arb_result_t res;
			n = eff_count();
			if (from >= n || to >= n || stored >= NE) begin
				dropped = 1;
			end else begin
				src[stored] = from;
				dst[stored] = to;
				cost[stored] = w;
				stored++;
			end
			if (!last) return;
			if (run_solver(sum)) begin
				res.weight = sum[47:0];
				res.none = 0;
			end else begin
				res.weight = '0;
				res.none = 1;
			end
			res.dropped = dropped;
			pending_q.push_back(res);
			stored = 0;
			dropped = 0;
		endfunction

		function bit check(logic [47:0] w, logic na, logic ed, output string why);
			arb_result_t x;
			if (pending_q.size() == 0) begin
				why = "result beat with nothing expected";
				return 0;
			end
			x = pending_q.pop_front();
			if (w !== x.weight || na !== x.none || ed !== x.dropped) begin
				why = $sformatf("got weight %0d none %b dropped %b, want %0d %b %b",
					$signed(w), na, ed, $signed(x.weight), x.none, x.dropped);
				return 0;
			end
			return 1;
		endfunction
	endclass

	logic               clk = 0;
	logic               arst_n = 0;
	logic               cfg_we = 0;
	logic               cfg_index = CFG_ROOT;
	logic [8:0]         cfg_data = '0;
	logic               edge_valid = 0;
	logic               edge_stall;
	logic [7:0]         edge_from = '0;
	logic [7:0]         edge_to = '0;
	logic signed [31:0] edge_weight = '0;
	logic               last_edge = 0;
	logic               result_valid;
	logic               result_stall = 0;
	logic signed [47:0] total_weight;
	logic               no_arborescence;
	logic               edges_dropped;

	arb_scoreboard sb = new();
	int     errors = 0;
	int     gap_pct = 0;
	int     stall_pct = 0;
	longint cycles = 0;
	int     sent = 0;

	min_spanning_arborescence_unit i_dut (.*);

	always #6 clk = ~clk;

	task report(string msg);
		$display("mismatch: %s", msg);
		errors++;
	endtask

	always @(posedge clk) begin
		string why;
		cycles++;
		if (cycles > CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
		if (arst_n && result_valid && !result_stall)
			if (!sb.check(total_weight, no_arborescence, edges_dropped, why))
				report(why);
	end

	always @(negedge clk)
		result_stall <= ($urandom_range(0, 99) < stall_pct);

	// called at a falling edge, returns at a falling edge
	task send_edge(int from, int to, logic signed [31:0] w, bit last);
		if ($urandom_range(0, 99) < gap_pct) begin
			edge_valid <= 0;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		edge_valid <= 1;
		edge_from <= from[7:0];
		edge_to <= to[7:0];
		edge_weight <= w;
		last_edge <= last;
		do @(posedge clk); while (edge_stall);
		sb.note_edge(from[7:0], to[7:0], w, last);
		sent++;
		@(negedge clk);
	endtask

	task quiesce();
		edge_valid <= 0;
		while (sb.pending_q.size() != 0) @(negedge clk);
		repeat (4) @(negedge clk);
	endtask

	task set_config(int root, int count);
		cfg_we <= 1;
		cfg_index <= CFG_ROOT;
		cfg_data <= root[8:0];
		sb.write_reg(CFG_ROOT, root[8:0]);
		@(negedge clk);
		cfg_index <= CFG_VCOUNT;
		cfg_data <= count[8:0];
		sb.write_reg(CFG_VCOUNT, count[8:0]);
		@(negedge clk);
		cfg_we <= 0;
		@(negedge clk);
	endtask

	function logic signed [31:0] pick_weight();
		int k;
		k = $urandom_range(0, 99);
		if (k < 70) return $signed($urandom_range(0, 100)) - 50;
		if (k < 90) return $urandom;
		case ($urandom_range(0, 3))
			0: return 32'sh7fffffff;
			1: return 32'sh80000000;
			2: return -1;
			default: return 0;
		endcase
	endfunction

	task random_graph(int g);
		int cnt, n, root, extra, u, total;
		case ((g / 10) % 4)
			0: begin gap_pct = 0; stall_pct = 0; end
			1: begin gap_pct = 77; stall_pct = 0; end
			2: begin gap_pct = 0; stall_pct = 77; end
			default: begin gap_pct = 33; stall_pct = 33; end
		endcase
		if ($urandom_range(0, 99) < 85) begin
			cnt = $urandom_range(2, 10);
		end else begin
			case ($urandom_range(0, 4))
				0: cnt = 0;
				1: cnt = 1;
				2: cnt = $urandom_range(256, 511);
				3: cnt = 256;
				default: cnt = $urandom_range(11, 40);
			endcase
		end
		n = (cnt == 0) ? 1 : (cnt > NV ? NV : cnt);
		root = ($urandom_range(0, 99) < 90) ? $urandom_range(0, n - 1) : $urandom_range(0, 255);
		set_config(root, cnt);
		extra = $urandom_range(0, (n > 12) ? 12 : 2 * n);
		total = 0;
		if (n <= 40 || $urandom_range(0, 99) < 20)
			for (int v = 0; v < n; v++)
				if (v != root && $urandom_range(0, 99) < 92) begin
					u = $urandom_range(0, n - 1);
					send_edge(u, v, pick_weight(), 0);
					total++;
				end
		for (int i = 0; i <= extra; i++) begin
			if ($urandom_range(0, 99) < 6)
				send_edge($urandom_range(0, 255), $urandom_range(0, 255), pick_weight(), i == extra);
			else
				send_edge($urandom_range(0, n - 1), $urandom_range(0, n - 1), pick_weight(),
					i == extra);
		end
		quiesce();
	endtask

	initial begin
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1;
		@(negedge clk);

		// reset settings: single vertex
		send_edge(0, 0, 32'sh80000000, 1);
		quiesce();

		// cycle with tie, self-loop, edge into root and a dropped edge
		set_config(0, 3);
		send_edge(0, 1, 10, 0);
		send_edge(1, 2, 1, 0);
		send_edge(2, 1, 1, 0);
		send_edge(0, 2, 20, 0);
		send_edge(2, 0, 3, 0);
		send_edge(1, 1, 5, 0);
		send_edge(0, 1, 10, 0);
		send_edge(5, 1, 7, 1);
		quiesce();

		set_config(2, 3);
		send_edge(255, 255, 32'sh7fffffff, 0);
		send_edge(0, 1, -1, 0);
		send_edge(2, 0, 4, 1);
		quiesce();

		// root beyond count, count zero
		set_config(200, 0);
		send_edge(0, 0, 9, 1);
		quiesce();

		// vertex 3 unreachable
		set_config(0, 4);
		send_edge(0, 1, 1, 0);
		send_edge(1, 2, 1, 1);
		quiesce();

		// count lowered with edges already stored
		set_config(0, 5);
		send_edge(0, 1, 3, 0);
		send_edge(3, 4, 2, 0);
		send_edge(4, 1, 1, 0);
		quiesce();
		set_config(0, 3);
		send_edge(1, 2, -7, 1);
		quiesce();

		// count above the maximum
		set_config(255, 511);
		send_edge(255, 0, 1, 0);
		send_edge(0, 254, 2, 1);
		quiesce();

		for (int g = 0; sent < 1800; g++)
			random_graph(g);

		repeat (100) @(negedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule

// ===== filelist.f =====
rtl/msa_pkg.sv
rtl/msa_ram.sv
rtl/min_spanning_arborescence_unit.sv
rtl/msa_checker.sv
sim/testbench.sv
